// ===== hw/rtl/bucketed_hash_table_defines.svh =====
// assertion macros shared by the hash table rtl
`ifndef BUCKETED_HASH_TABLE_DEFINES_SVH
`define BUCKETED_HASH_TABLE_DEFINES_SVH

// same-cycle implication, checking held off during reset
`define BHT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bucketed hash table check failed");

// next-cycle implication, checking held off during reset
`define BHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bucketed hash table check failed");

`endif

// ===== hw/rtl/bht_pkg.sv =====
// shared constants and codes of the bucketed hash table
package bht_pkg;

  localparam int NUM_BUCKETS_DEF      = 10;
  localparam int SLOTS_PER_BUCKET_DEF = 10;

  localparam int VALUE_W  = 31;
  localparam int STATUS_W = 2;
  localparam int ROW_W    = 4;
  localparam int COLUMN_W = 4;

  // remainder unit consumes the key in fixed chunks
  localparam int MOD_CHUNK  = 8;
  localparam int MOD_CHUNKS = 4;
  localparam int MOD_PAD_W  = MOD_CHUNK * MOD_CHUNKS;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd3;

endpackage

// ===== hw/rtl/bht_ram.sv =====
// generic simple dual-port ram with registered read
module bht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bht_mod.sv =====
// key modulo bucket count, one byte of the key per cycle
module bht_mod #(
  parameter int NUM_BUCKETS = bht_pkg::NUM_BUCKETS_DEF,
  localparam int RW = $clog2(NUM_BUCKETS)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic [bht_pkg::VALUE_W-1:0] value,
  output logic                        done,
  output logic [RW-1:0]               rem
);

  localparam int CNT_W = $clog2(bht_pkg::MOD_CHUNKS);
  localparam int BN    = 1 << bht_pkg::MOD_CHUNK;
  localparam int AN    = 1 << RW;
  localparam logic [RW:0] NB = (RW+1)'(NUM_BUCKETS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(bht_pkg::MOD_CHUNKS - 1);

  // chunk value modulo the bucket count
  function automatic logic [BN*RW-1:0] byte_tbl();
    logic [BN*RW-1:0] t;
    t = '0;
    for (int b = 0; b < BN; b++) begin
      t[b*RW +: RW] = RW'(b % NUM_BUCKETS);
    end
    return t;
  endfunction

  // partial remainder times the chunk base, modulo the bucket count
  function automatic logic [AN*RW-1:0] shift_tbl();
    logic [AN*RW-1:0] t;
    t = '0;
    for (int a = 0; a < AN; a++) begin
      t[a*RW +: RW] = RW'((a * BN) % NUM_BUCKETS);
    end
    return t;
  endfunction

  localparam logic [BN*RW-1:0] BYTE_TBL  = byte_tbl();
  localparam logic [AN*RW-1:0] SHIFT_TBL = shift_tbl();

  logic [bht_pkg::MOD_PAD_W-1:0] sh_r;
  logic [RW-1:0]                 rem_r, rem_nxt;
  logic [CNT_W-1:0]              cnt_r;
  logic                          active_r, done_r;
  logic [bht_pkg::MOD_CHUNK-1:0] chunk;

  assign chunk = sh_r[bht_pkg::MOD_PAD_W-1 -: bht_pkg::MOD_CHUNK];

  // two residues below the bucket count, so one compare and subtract folds the sum
  always_comb begin
    logic [RW:0] t;
    t = {1'b0, SHIFT_TBL[rem_r*RW +: RW]} + {1'b0, BYTE_TBL[chunk*RW +: RW]};
    if (t >= NB) begin
      t = t - NB;
    end
    rem_nxt = t[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (load) begin
        active_r <= 1'b1;
        cnt_r    <= '0;
      end else if (active_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sh_r  <= bht_pkg::MOD_PAD_W'(value);
      rem_r <= '0;
    end else if (active_r) begin
      sh_r  <= sh_r << bht_pkg::MOD_CHUNK;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== hw/rtl/bucketed_hash_table.sv =====
// bucketed hash table top level: row memory, remainder unit and control
//
//   channel   ports                                       handshake
//   input     in_action, in_value                         start & !busy
//   result    out_status, out_row, out_column             out_strobe, one cycle
//
// one item runs from accept through the remainder unit (one key byte a cycle,
// then its done flag), the bucket row read, the compare and row write-back,
// and the result cycle, in which busy is already low again.
// rst_n (synchronous) empties the table at once through per-bucket row
// valid flops; no clearing pass. results cannot be stalled.
`include "bucketed_hash_table_defines.svh"

module bucketed_hash_table #(
  parameter int NUM_BUCKETS      = bht_pkg::NUM_BUCKETS_DEF,
  parameter int SLOTS_PER_BUCKET = bht_pkg::SLOTS_PER_BUCKET_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [bht_pkg::VALUE_W-1:0]   in_value,
  output logic                          out_strobe,
  output logic [bht_pkg::STATUS_W-1:0]  out_status,
  output logic [bht_pkg::ROW_W-1:0]     out_row,
  output logic [bht_pkg::COLUMN_W-1:0]  out_column
);

  localparam int VW = bht_pkg::VALUE_W;
  localparam int RW = $clog2(NUM_BUCKETS);
  localparam int CW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int SW = SLOTS_PER_BUCKET;
  localparam int WORD_W = SW * VW + SW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MOD  = 4'b0010,
    S_RD   = 4'b0100,
    S_CMP  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic                   act_r;
  logic [VW-1:0]          val_r;
  logic [NUM_BUCKETS-1:0] row_valid_r;

  logic                   mod_done;
  logic [RW-1:0]          row;

  logic [WORD_W-1:0]      rd_word, wr_word;
  logic [SW-1:0]          slot_v, wr_v;
  logic [SW*VW-1:0]       wr_vals;
  logic                   we;

  logic                   has_free, has_match;
  logic [CW-1:0]          free_col, match_col;

  logic                          out_strobe_r;
  logic [bht_pkg::STATUS_W-1:0]  out_status_r;
  logic [bht_pkg::ROW_W-1:0]     out_row_r;
  logic [bht_pkg::COLUMN_W-1:0]  out_column_r;

  wire accept = start && (state_r == S_IDLE);

  bht_mod #(
    .NUM_BUCKETS(NUM_BUCKETS)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (accept),
    .value (in_value),
    .done  (mod_done),
    .rem   (row)
  );

  // one word per bucket: slot valid bits above the slot keys
  bht_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NUM_BUCKETS)
  ) u_rows (
    .clk   (clk),
    .we    (we),
    .waddr (row),
    .wdata (wr_word),
    .raddr (row),
    .rdata (rd_word)
  );

  // a bucket never written reads as empty
  assign slot_v = row_valid_r[row] ? rd_word[SW*VW +: SW] : '0;

  always_comb begin
    has_free  = 1'b0;
    free_col  = '0;
    has_match = 1'b0;
    match_col = '0;
    for (int i = SW - 1; i >= 0; i--) begin
      if (!slot_v[i]) begin
        has_free = 1'b1;
        free_col = CW'(i);
      end
      if (slot_v[i] && (rd_word[i*VW +: VW] == val_r)) begin
        has_match = 1'b1;
        match_col = CW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SW; i++) begin
      if (CW'(i) == free_col) begin
        wr_vals[i*VW +: VW] = val_r;
        wr_v[i]             = 1'b1;
      end else begin
        wr_vals[i*VW +: VW] = rd_word[i*VW +: VW];
        wr_v[i]             = slot_v[i];
      end
    end
  end

  assign wr_word = {wr_v, wr_vals};
  assign we = (state_r == S_CMP) && (act_r == bht_pkg::ACT_INSERT) && has_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_MOD;
      S_MOD:  if (mod_done) state_nxt = S_RD;
      S_RD:   state_nxt = S_CMP;
      S_CMP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      row_valid_r  <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == S_CMP);
      if (we) begin
        row_valid_r[row] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_action;
      val_r <= in_value;
    end
    if (state_r == S_CMP) begin
      out_row_r <= bht_pkg::ROW_W'(row);
      if (act_r == bht_pkg::ACT_INSERT) begin
        out_status_r <= has_free ? bht_pkg::ST_INSERTED : bht_pkg::ST_FULL;
        out_column_r <= has_free ? bht_pkg::COLUMN_W'(free_col) : '0;
      end else begin
        out_status_r <= has_match ? bht_pkg::ST_FOUND : bht_pkg::ST_MISSING;
        out_column_r <= has_match ? bht_pkg::COLUMN_W'(match_col) : '0;
      end
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_status = out_status_r;
  assign out_row    = out_row_r;
  assign out_column = out_column_r;

  `BHT_ASSERT_NOW(a_strobe_when_idle, clk, rst_n, out_strobe, !busy)
  `BHT_ASSERT_NEXT(a_accept_goes_busy, clk, rst_n, start && !busy, busy)
  `BHT_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_strobe, !out_strobe)
  `BHT_ASSERT_NEXT(a_cmp_gives_result, clk, rst_n, state_r == S_CMP, out_strobe)

endmodule

// ===== verif/tb_bucketed_hash_table.sv =====
// testbench for the bucketed hash table: directed and random inserts and searches
`timescale 1ns / 1ps

module tb_bucketed_hash_table;

  localparam int BUCKETS   = bht_pkg::NUM_BUCKETS_DEF;
  localparam int SLOTS     = bht_pkg::SLOTS_PER_BUCKET_DEF;
  localparam int NUM_SLOTS = BUCKETS * SLOTS;
  localparam logic [bht_pkg::VALUE_W-1:0] KEY_MAX = {bht_pkg::VALUE_W{1'b1}};

  typedef struct packed {
    logic [bht_pkg::STATUS_W-1:0] status;
    logic [bht_pkg::ROW_W-1:0]    row;
    logic [bht_pkg::COLUMN_W-1:0] column;
  } lookup_result_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic                         in_action;
  logic [bht_pkg::VALUE_W-1:0]  in_value;
  logic                         out_strobe;
  logic [bht_pkg::STATUS_W-1:0] out_status;
  logic [bht_pkg::ROW_W-1:0]    out_row;
  logic [bht_pkg::COLUMN_W-1:0] out_column;

  // shadow copy of the table
  logic [bht_pkg::VALUE_W-1:0] shadow_key [NUM_SLOTS];
  bit                          shadow_used [NUM_SLOTS];

  lookup_result_t              pending_results [$];
  logic [bht_pkg::VALUE_W-1:0] stored_keys [$];

  bit burst_mode = 1'b0;
  int err_count  = 0;
  int word_count = 0;
  int n_inserted = 0;
  int n_dropped  = 0;
  int n_found    = 0;
  int n_missed   = 0;

  always #10 clk = ~clk;

  bucketed_hash_table #(
    .NUM_BUCKETS      (BUCKETS),
    .SLOTS_PER_BUCKET (SLOTS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_action  (in_action),
    .in_value   (in_value),
    .out_strobe (out_strobe),
    .out_status (out_status),
    .out_row    (out_row),
    .out_column (out_column)
  );

  function automatic lookup_result_t predict_lookup(logic act,
                                                    logic [bht_pkg::VALUE_W-1:0] key);
    int unsigned    bucket;
    int unsigned    base;
    lookup_result_t res;
    bucket     = int'({1'b0, key}) % BUCKETS;
    base       = bucket * SLOTS;
    res.row    = bucket[bht_pkg::ROW_W-1:0];
    res.column = '0;
    if (act == bht_pkg::ACT_INSERT) begin
      res.status = bht_pkg::ST_FULL;
      for (int c = 0; c < SLOTS; c++) begin
        if (!shadow_used[base + c]) begin
          shadow_key[base + c]  = key;
          shadow_used[base + c] = 1'b1;
          res.status = bht_pkg::ST_INSERTED;
          res.column = c[bht_pkg::COLUMN_W-1:0];
          break;
        end
      end
      if (res.status == bht_pkg::ST_INSERTED) n_inserted++;
      else n_dropped++;
    end else begin
      res.status = bht_pkg::ST_MISSING;
      for (int c = 0; c < SLOTS; c++) begin
        if (shadow_used[base + c] && shadow_key[base + c] == key) begin
          res.status = bht_pkg::ST_FOUND;
          res.column = c[bht_pkg::COLUMN_W-1:0];
          break;
        end
      end
      if (res.status == bht_pkg::ST_FOUND) n_found++;
      else n_missed++;
    end
    return res;
  endfunction

  // start stays high across back-to-back words; it is only lowered for a gap
  task automatic send_word(input logic act, input logic [bht_pkg::VALUE_W-1:0] key);
    int             gap;
    lookup_result_t res;
    gap = burst_mode ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    in_action <= act;
    in_value  <= key;
    do @(posedge clk); while (busy !== 1'b0);
    res = predict_lookup(act, key);
    pending_results.push_back(res);
    if (act == bht_pkg::ACT_INSERT && res.status == bht_pkg::ST_INSERTED)
      stored_keys.push_back(key);
    word_count++;
  endtask

  task automatic wait_until_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    lookup_result_t got;
    lookup_result_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      got = '{status: out_status, row: out_row, column: out_column};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d row %0d column %0d",
                 $time, got.status, got.row, got.column);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status,
                   got.status);
          err_count++;
        end
        if (got.row !== want.row) begin
          $display("%0t: row mismatch, expected %0d, got %0d", $time, want.row, got.row);
          err_count++;
        end
        if (got.column !== want.column) begin
          $display("%0t: column mismatch, expected %0d, got %0d", $time, want.column,
                   got.column);
          err_count++;
        end
      end
    end
  end

  function automatic logic [bht_pkg::VALUE_W-1:0] pick_key(bit narrow);
    logic [bht_pkg::VALUE_W-1:0] k;
    if (narrow) k = bht_pkg::VALUE_W'($urandom_range(0, 199));
    else k = bht_pkg::VALUE_W'($urandom);
    return k;
  endfunction

  // extremes of the key, duplicates and a miss in a used bucket
  task automatic test_basic_ops();
    send_word(bht_pkg::ACT_INSERT, '0);
    send_word(bht_pkg::ACT_SEARCH, '0);
    send_word(bht_pkg::ACT_SEARCH, bht_pkg::VALUE_W'(10));
    send_word(bht_pkg::ACT_INSERT, '0);
    send_word(bht_pkg::ACT_SEARCH, '0);
    send_word(bht_pkg::ACT_INSERT, KEY_MAX);
    send_word(bht_pkg::ACT_SEARCH, KEY_MAX);
    send_word(bht_pkg::ACT_SEARCH, KEY_MAX - bht_pkg::VALUE_W'(10));
    send_word(bht_pkg::ACT_SEARCH, bht_pkg::VALUE_W'(5));
  endtask

  // fill one bucket, overflow it, then find its first and last slot
  task automatic test_full_bucket();
    logic [bht_pkg::VALUE_W-1:0] keys [SLOTS];
    for (int i = 0; i < SLOTS; i++) begin
      keys[i] = bht_pkg::VALUE_W'(3 + 10 * $urandom_range(0, 200_000_000));
      send_word(bht_pkg::ACT_INSERT, keys[i]);
    end
    send_word(bht_pkg::ACT_INSERT, bht_pkg::VALUE_W'(13));
    send_word(bht_pkg::ACT_SEARCH, keys[SLOTS-1]);
    send_word(bht_pkg::ACT_SEARCH, keys[0]);
  endtask

  task automatic run_random_mix(int n_words, int insert_pct, bit narrow);
    logic                        act;
    logic [bht_pkg::VALUE_W-1:0] key;
    for (int i = 0; i < n_words; i++) begin
      if ($urandom_range(0, 39) == 0) burst_mode = ~burst_mode;
      act = ($urandom_range(0, 99) < insert_pct) ? bht_pkg::ACT_INSERT : bht_pkg::ACT_SEARCH;
      if (stored_keys.size() != 0 && $urandom_range(0, 1) == 1)
        key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      else
        key = pick_key(narrow);
      send_word(act, key);
    end
    burst_mode = 1'b0;
  endtask

  // wide keys: mostly misses and hits on stored keys while the table fills slowly
  task automatic test_random_wide();
    run_random_mix(300, 30, 1'b0);
  endtask

  // narrow keys: heavy collisions, duplicates and full buckets
  task automatic test_random_narrow();
    run_random_mix(530, 40, 1'b1);
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_action <= bht_pkg::ACT_INSERT;
    in_value  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_full_bucket();
    test_random_wide();
    wait_until_idle();
    test_random_narrow();

    wait_until_idle();
    repeat (20) @(posedge clk);
    $display("run covered %0d words: %0d inserted, %0d dropped on a full bucket",
             word_count, n_inserted, n_dropped);
    $display("searches: %0d found, %0d missed", n_found, n_missed);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/bht_pkg.sv
hw/rtl/bht_ram.sv
hw/rtl/bht_mod.sv
hw/rtl/bucketed_hash_table.sv
verif/tb_bucketed_hash_table.sv
